FILE: sv/kcs_pkg.sv
package kcs_pkg;

   localparam int NCHARS     = 95;
   localparam int FIRST_CHAR = 32;
   localparam int LAST_CHAR  = 126;
   localparam int IDX_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int OP_W       = 3;
   localparam int ST_W       = 2;
   localparam int ADDR_W     = IDX_W + 1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [OP_W-1:0]   op_type;
   typedef logic [ST_W-1:0]   status_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam op_type OP_CLEAR   = 3'd0;
   localparam op_type OP_APPEND  = 3'd1;
   localparam op_type OP_BUILD   = 3'd2;
   localparam op_type OP_ENCRYPT = 3'd3;
   localparam op_type OP_DECRYPT = 3'd4;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_KEY_IGNORE = 2'd1;
   localparam status_type ST_NOT_BUILT = 2'd2;
   localparam status_type ST_EMPTY_KEY = 2'd3;

   // Upper address bit selects one half of each memory.
   localparam logic HALF_SEQ = 1'b0;
   localparam logic HALF_POS = 1'b1;
   localparam logic HALF_FWD = 1'b0;
   localparam logic HALF_INV = 1'b1;

   typedef struct packed {
      logic     en;
      addr_type addr;
      idx_type  data;
   } ram_wr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } ram_rd_type;

endpackage

FILE: sv/kcs_if.sv
interface kcs_req_if;
   logic                 valid;
   logic                 ready;
   kcs_pkg::op_type      opcode;
   kcs_pkg::char_type    data_char;

   modport source (output valid, output opcode, output data_char, input ready);
   modport sink (input valid, input opcode, input data_char, output ready);
endinterface

interface kcs_rsp_if;
   logic                 valid;
   logic                 ready;
   kcs_pkg::char_type    result_char;
   kcs_pkg::status_type  status;

   modport source (output valid, output result_char, output status, input ready);
   modport sink (input valid, input result_char, input status, output ready);
endinterface

FILE: sv/kcs_ram.sv
module kcs_ram (
   input  logic                clock,
   input  kcs_pkg::ram_wr_type wr,
   input  kcs_pkg::ram_rd_type rd,
   output kcs_pkg::idx_type    rd_data
);

   kcs_pkg::idx_type mem [2**kcs_pkg::ADDR_W];
   kcs_pkg::idx_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/keyword_columnar_substitution_cipher.sv
// Keyword columnar substitution cipher over the printable characters 32..126.
// Items arrive on req (opcode, data_char) and each gives exactly one item on
// rsp (result_char, status), in order. Clear, encrypt and decrypt leave the
// block idle, so a stream of text flows at one item per cycle while rsp.ready
// is high; an accepted key character also passes through S_APPEND2, as it
// writes two entries of the key memory. A result passes through the lookup
// stage and then the output register before it is presented on rsp.
// A build walks the key memory and the table memory one entry per cycle:
// a fill pass, a column scan, the column reads and an inverse pass, during
// which req.ready is low.
// Reset (synchronous) empties the keyword, clears the character marks and
// marks the table as not built; the memories are not cleared, as no entry
// is read before it has been written.
// When the receiver stalls, the finished result is held on rsp and one more
// item can be taken into the lookup stage; after that req.ready drops until
// rsp.ready returns.
module keyword_columnar_substitution_cipher #(
   parameter int MAX_KEY_LEN = 32
) (
   input logic       clock,
   input logic       reset,
   kcs_req_if.sink   req,
   kcs_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND2,
      S_FILL,
      S_SCAN,
      S_POSW,
      S_COL,
      S_INV,
      S_INVD
   } state_type;

   localparam kcs_pkg::idx_type LAST_IDX = kcs_pkg::IDX_W'(kcs_pkg::NCHARS - 1);

   state_type                   state_ff, state_in;
   kcs_pkg::idx_type            len_ff, len_in;
   logic [kcs_pkg::NCHARS-1:0]  marks_ff, marks_in;
   logic                        built_ff, built_in;
   kcs_pkg::idx_type            v_ff, v_in;
   kcs_pkg::idx_type            n_ff, n_in;
   logic [kcs_pkg::ADDR_W-1:0]  p_ff, p_in;
   kcs_pkg::idx_type            k_ff, k_in;
   logic                        rdp_ff, rdp_in;
   kcs_pkg::idx_type            col_ff, col_in;
   kcs_pkg::idx_type            chidx_ff, chidx_in;

   logic                        a_valid_ff, a_valid_in;
   logic                        a_ram_ff, a_ram_in;
   kcs_pkg::char_type           a_char_ff, a_char_in;
   kcs_pkg::status_type         a_status_ff, a_status_in;

   logic                        res_valid_ff, res_valid_in;
   kcs_pkg::char_type           res_char_ff, res_char_in;
   kcs_pkg::status_type         res_status_ff, res_status_in;

   kcs_pkg::ram_wr_type         key_wr, tab_wr;
   kcs_pkg::ram_rd_type         key_rd, tab_rd;
   kcs_pkg::idx_type            key_rdata, tab_rdata;

   logic                        out_free;
   logic                        ready;
   logic                        accept;
   logic                        printable;
   kcs_pkg::char_type           ch_off;
   kcs_pkg::idx_type            cidx;
   logic                        mark_hit;
   kcs_pkg::char_type           a_data;

   kcs_ram u_key_ram (
      .clock   (clock),
      .wr      (key_wr),
      .rd      (key_rd),
      .rd_data (key_rdata)
   );

   kcs_ram u_tab_ram (
      .clock   (clock),
      .wr      (tab_wr),
      .rd      (tab_rd),
      .rd_data (tab_rdata)
   );

   assign out_free  = !res_valid_ff || rsp.ready;
   assign ready     = (state_ff == S_IDLE) && (!a_valid_ff || out_free);
   assign accept    = req.valid && ready;
   assign printable = (req.data_char >= kcs_pkg::CHAR_W'(kcs_pkg::FIRST_CHAR)) &&
                      (req.data_char <= kcs_pkg::CHAR_W'(kcs_pkg::LAST_CHAR));
   assign ch_off    = req.data_char - kcs_pkg::CHAR_W'(kcs_pkg::FIRST_CHAR);
   assign cidx      = ch_off[kcs_pkg::IDX_W-1:0];
   assign mark_hit  = printable && marks_ff[cidx];
   assign a_data    = a_ram_ff ?
                      (kcs_pkg::CHAR_W'(tab_rdata) + kcs_pkg::CHAR_W'(kcs_pkg::FIRST_CHAR)) :
                      a_char_ff;

   assign req.ready       = ready;
   assign rsp.valid       = res_valid_ff;
   assign rsp.result_char = res_char_ff;
   assign rsp.status      = res_status_ff;

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      marks_in      = marks_ff;
      built_in      = built_ff;
      v_in          = v_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      k_in          = k_ff;
      rdp_in        = rdp_ff;
      col_in        = col_ff;
      chidx_in      = chidx_ff;
      a_valid_in    = a_valid_ff;
      a_ram_in      = a_ram_ff;
      a_char_in     = a_char_ff;
      a_status_in   = a_status_ff;
      res_valid_in  = res_valid_ff;
      res_char_in   = res_char_ff;
      res_status_in = res_status_ff;
      key_wr        = '0;
      tab_wr        = '0;
      key_rd        = '0;
      tab_rd        = '0;

      // The lookup stage moves into the output register whenever it is free.
      if (out_free) begin
         res_valid_in  = a_valid_ff;
         res_char_in   = a_data;
         res_status_in = a_status_ff;
         a_valid_in    = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               a_valid_in  = 1'b1;
               a_ram_in    = 1'b0;
               a_char_in   = '0;
               a_status_in = kcs_pkg::ST_OK;
               unique case (req.opcode) inside
                  kcs_pkg::OP_CLEAR: begin
                     len_in   = '0;
                     marks_in = '0;
                  end
                  kcs_pkg::OP_APPEND: begin
                     if (!printable || (len_ff >= kcs_pkg::IDX_W'(MAX_KEY_LEN)) ||
                         mark_hit) begin
                        a_status_in = kcs_pkg::ST_KEY_IGNORE;
                     end else begin
                        key_wr         = '{en: 1'b1, addr: {kcs_pkg::HALF_SEQ, len_ff},
                                           data: cidx};
                        len_in         = len_ff + kcs_pkg::IDX_W'(1);
                        marks_in[cidx] = 1'b1;
                        col_in         = len_ff;
                        chidx_in       = cidx;
                        state_in       = S_APPEND2;
                     end
                  end
                  kcs_pkg::OP_BUILD: begin
                     if (len_ff == '0) begin
                        a_status_in = kcs_pkg::ST_EMPTY_KEY;
                     end else begin
                        // The result is issued when the build finishes.
                        a_valid_in = 1'b0;
                        v_in       = '0;
                        n_in       = len_ff;
                        state_in   = S_FILL;
                     end
                  end
                  kcs_pkg::OP_ENCRYPT, kcs_pkg::OP_DECRYPT: begin
                     if (!built_ff) begin
                        a_status_in = kcs_pkg::ST_NOT_BUILT;
                     end else if (!printable) begin
                        a_char_in = req.data_char;
                     end else begin
                        a_ram_in = 1'b1;
                        tab_rd   = '{en: 1'b1,
                                     addr: {(req.opcode == kcs_pkg::OP_DECRYPT) ?
                                            kcs_pkg::HALF_INV : kcs_pkg::HALF_FWD, cidx}};
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_APPEND2: begin
            key_wr   = '{en: 1'b1, addr: {kcs_pkg::HALF_POS, chidx_ff}, data: col_ff};
            state_in = S_IDLE;
         end
         S_FILL: begin
            // Unused characters follow the keyword in ascending order.
            if (!marks_ff[v_ff]) begin
               key_wr = '{en: 1'b1, addr: {kcs_pkg::HALF_SEQ, n_ff}, data: v_ff};
               n_in   = n_ff + kcs_pkg::IDX_W'(1);
            end
            if (v_ff == LAST_IDX) begin
               v_in     = '0;
               k_in     = '0;
               state_in = S_SCAN;
            end else begin
               v_in = v_ff + kcs_pkg::IDX_W'(1);
            end
         end
         S_SCAN: begin
            if (marks_ff[v_ff]) begin
               key_rd   = '{en: 1'b1, addr: {kcs_pkg::HALF_POS, v_ff}};
               state_in = S_POSW;
            end else if (v_ff == LAST_IDX) begin
               v_in     = '0;
               state_in = S_INV;
            end else begin
               v_in = v_ff + kcs_pkg::IDX_W'(1);
            end
         end
         S_POSW: begin
            // key_rdata is the column of this key character.
            key_rd   = '{en: 1'b1, addr: {kcs_pkg::HALF_SEQ, key_rdata}};
            p_in     = {1'b0, key_rdata} + {1'b0, len_ff};
            rdp_in   = 1'b1;
            state_in = S_COL;
         end
         S_COL: begin
            if (rdp_ff) begin
               tab_wr = '{en: 1'b1, addr: {kcs_pkg::HALF_FWD, k_ff}, data: key_rdata};
               k_in   = k_ff + kcs_pkg::IDX_W'(1);
            end
            if (p_ff < kcs_pkg::ADDR_W'(kcs_pkg::NCHARS)) begin
               key_rd = '{en: 1'b1,
                          addr: {kcs_pkg::HALF_SEQ, p_ff[kcs_pkg::IDX_W-1:0]}};
               p_in   = p_ff + {1'b0, len_ff};
               rdp_in = 1'b1;
            end else begin
               rdp_in = 1'b0;
               if (v_ff == LAST_IDX) begin
                  v_in     = '0;
                  state_in = S_INV;
               end else begin
                  v_in     = v_ff + kcs_pkg::IDX_W'(1);
                  state_in = S_SCAN;
               end
            end
         end
         S_INV: begin
            tab_rd   = '{en: 1'b1, addr: {kcs_pkg::HALF_FWD, v_ff}};
            chidx_in = v_ff;
            rdp_in   = 1'b1;
            if (rdp_ff) begin
               tab_wr = '{en: 1'b1, addr: {kcs_pkg::HALF_INV, tab_rdata}, data: chidx_ff};
            end
            if (v_ff == LAST_IDX) begin
               state_in = S_INVD;
            end else begin
               v_in = v_ff + kcs_pkg::IDX_W'(1);
            end
         end
         S_INVD: begin
            tab_wr      = '{en: 1'b1, addr: {kcs_pkg::HALF_INV, tab_rdata}, data: chidx_ff};
            rdp_in      = 1'b0;
            built_in    = 1'b1;
            a_valid_in  = 1'b1;
            a_ram_in    = 1'b0;
            a_char_in   = '0;
            a_status_in = kcs_pkg::ST_OK;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         marks_ff     <= '0;
         built_ff     <= 1'b0;
         rdp_ff       <= 1'b0;
         a_valid_ff   <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         marks_ff     <= marks_in;
         built_ff     <= built_in;
         rdp_ff       <= rdp_in;
         a_valid_ff   <= a_valid_in;
         res_valid_ff <= res_valid_in;
      end
      v_ff          <= v_in;
      n_ff          <= n_in;
      p_ff          <= p_in;
      k_ff          <= k_in;
      col_ff        <= col_in;
      chidx_ff      <= chidx_in;
      a_ram_ff      <= a_ram_in;
      a_char_ff     <= a_char_in;
      a_status_ff   <= a_status_in;
      res_char_ff   <= res_char_in;
      res_status_ff <= res_status_in;
   end

   // Every kept key character carries exactly one mark.
   a_marks_match_len: assert property (@(posedge clock) disable iff (reset)
      $countones(marks_ff) == int'(len_ff))
      else $error("character marks disagree with the keyword length");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      len_ff <= kcs_pkg::IDX_W'(MAX_KEY_LEN))
      else $error("keyword length beyond its limit");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready)
      else $error("item taken while a build or append is running");

   a_build_sets_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INVD) |=> (built_ff && a_valid_ff))
      else $error("finished build left no table or no result");

endmodule

FILE: tb/tb_keyword_columnar_substitution_cipher.sv
`timescale 1ns / 1ps

module tb_keyword_columnar_substitution_cipher;

   localparam int KEY_CAP     = 32;
   localparam int ITEM_TARGET = 1850;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 40;
   // Opcodes above decrypt are spare and leave the block untouched.
   localparam kcs_pkg::op_type OP_SPARE_FIRST = kcs_pkg::op_type'(kcs_pkg::OP_DECRYPT + 1);
   localparam kcs_pkg::op_type OP_SPARE_LAST  = '1;

   typedef struct {
      kcs_pkg::char_type   result_char;
      kcs_pkg::status_type status;
      kcs_pkg::op_type     opcode;
      kcs_pkg::char_type   data_char;
   } cipher_output_type;

   class cipher_predictor;
      kcs_pkg::idx_type  key_codes[KEY_CAP];
      int                key_len;
      bit                char_used[kcs_pkg::NCHARS];
      kcs_pkg::idx_type  fwd_tab[kcs_pkg::NCHARS];
      kcs_pkg::idx_type  inv_tab[kcs_pkg::NCHARS];
      bit                tables_ready;
      cipher_output_type expected_outputs[$];
      int                fail_count;

      function new();
         key_len      = 0;
         char_used    = '{default: 1'b0};
         tables_ready = 1'b0;
         fail_count   = 0;
      endfunction

      // Keyword first, then the unused characters, laid out row by row; the
      // columns are then read in ascending order of their key character.
      function void rebuild_tables();
         kcs_pkg::idx_type grid[kcs_pkg::NCHARS];
         int               n;
         int               k;
         int               p;
         n = 0;
         k = 0;
         for (int c = 0; c < key_len; c++) begin
            grid[n] = key_codes[c];
            n++;
         end
         for (int v = 0; v < kcs_pkg::NCHARS; v++) begin
            if (!char_used[v] && n < kcs_pkg::NCHARS) begin
               grid[n] = kcs_pkg::idx_type'(v);
               n++;
            end
         end
         for (int v = 0; v < kcs_pkg::NCHARS; v++) begin
            if (char_used[v]) begin
               for (int c = 0; c < key_len; c++) begin
                  if (key_codes[c] == kcs_pkg::idx_type'(v)) begin
                     for (p = c; p < n && k < kcs_pkg::NCHARS; p += key_len) begin
                        fwd_tab[k] = grid[p];
                        k++;
                     end
                     break;
                  end
               end
            end
         end
         for (int v = 0; v < kcs_pkg::NCHARS; v++)
            inv_tab[fwd_tab[v]] = kcs_pkg::idx_type'(v);
         tables_ready = 1'b1;
      endfunction

      function void predict_item(kcs_pkg::op_type op, kcs_pkg::char_type ch);
         cipher_output_type exp_out;
         bit                printable;
         kcs_pkg::idx_type  idx;
         printable           = (ch >= kcs_pkg::FIRST_CHAR) && (ch <= kcs_pkg::LAST_CHAR);
         idx                 = kcs_pkg::idx_type'(ch - kcs_pkg::FIRST_CHAR);
         exp_out.result_char = '0;
         exp_out.status      = kcs_pkg::ST_OK;
         exp_out.opcode      = op;
         exp_out.data_char   = ch;
         case (op) inside
            kcs_pkg::OP_CLEAR: begin
               key_len   = 0;
               char_used = '{default: 1'b0};
            end
            kcs_pkg::OP_APPEND: begin
               if (!printable || key_len >= KEY_CAP || char_used[idx]) begin
                  exp_out.status = kcs_pkg::ST_KEY_IGNORE;
               end else begin
                  key_codes[key_len] = idx;
                  key_len++;
                  char_used[idx] = 1'b1;
               end
            end
            kcs_pkg::OP_BUILD: begin
               if (key_len == 0)
                  exp_out.status = kcs_pkg::ST_EMPTY_KEY;
               else
                  rebuild_tables();
            end
            kcs_pkg::OP_ENCRYPT, kcs_pkg::OP_DECRYPT: begin
               if (!tables_ready)
                  exp_out.status = kcs_pkg::ST_NOT_BUILT;
               else if (!printable)
                  exp_out.result_char = ch;
               else if (op == kcs_pkg::OP_ENCRYPT)
                  exp_out.result_char =
                     kcs_pkg::char_type'(int'(fwd_tab[idx]) + kcs_pkg::FIRST_CHAR);
               else
                  exp_out.result_char =
                     kcs_pkg::char_type'(int'(inv_tab[idx]) + kcs_pkg::FIRST_CHAR);
            end
            default: ;
         endcase
         expected_outputs.push_back(exp_out);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t ns: %s", $realtime, msg);
         fail_count++;
      endtask

      task check_output(kcs_pkg::char_type res, kcs_pkg::status_type st);
         cipher_output_type exp_out;
         if (expected_outputs.size() == 0) begin
            report($sformatf("unexpected item result_char=%0h status=%0d", res, st));
         end else begin
            exp_out = expected_outputs.pop_front();
            if (res !== exp_out.result_char)
               report($sformatf("op %0d char %0h: result_char %0h, expected %0h",
                                exp_out.opcode, exp_out.data_char, res,
                                exp_out.result_char));
            if (st !== exp_out.status)
               report($sformatf("op %0d char %0h: status %0d, expected %0d",
                                exp_out.opcode, exp_out.data_char, st,
                                exp_out.status));
         end
      endtask

      function int pending();
         return expected_outputs.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   kcs_req_if req_ch ();
   kcs_rsp_if rsp_ch ();

   keyword_columnar_substitution_cipher #(
      .MAX_KEY_LEN(KEY_CAP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   cipher_predictor predictor = new();
   int              burst_left = 0;
   int              items_sent = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("keyword_columnar_substitution_cipher test failed");
      $finish;
   end

   // The receiver moves through four stall patterns in turn: none, random,
   // periodic and occasional long stalls.
   initial begin
      int rx_cycle;
      int hold_left;
      rsp_ch.ready = 1'b0;
      rx_cycle     = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         case ((rx_cycle / 300) % 4)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ((rx_cycle % 5) != 4);
            default: begin
               if (hold_left > 0) begin
                  hold_left--;
                  rsp_ch.ready <= 1'b0;
               end else if ($urandom_range(0, 15) == 0) begin
                  hold_left = $urandom_range(5, 20);
                  rsp_ch.ready <= 1'b0;
               end else begin
                  rsp_ch.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Both channels are sampled at the falling clock edge, ahead of the rising edge
   // that completes the handshake, when everything is settled.
   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         predictor.check_output(rsp_ch.result_char, rsp_ch.status);
   end

   task automatic send_item(input kcs_pkg::op_type op, input kcs_pkg::char_type ch);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.data_char <= ch;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      predictor.predict_item(op, ch);
      @(posedge clock);
      if (op <= kcs_pkg::OP_DECRYPT)
         items_sent++;
   endtask

   function automatic kcs_pkg::char_type any_printable();
      return kcs_pkg::char_type'($urandom_range(kcs_pkg::FIRST_CHAR, kcs_pkg::LAST_CHAR));
   endfunction

   function automatic kcs_pkg::char_type text_char();
      if ($urandom_range(0, 6) == 0)
         return kcs_pkg::char_type'($urandom);
      return any_printable();
   endfunction

   task automatic send_text(input int count);
      for (int i = 0; i < count; i++)
         send_item($urandom_range(0, 1) ? kcs_pkg::OP_ENCRYPT : kcs_pkg::OP_DECRYPT,
                   text_char());
   endtask

   task automatic load_keyword(input int count, input bit distinct);
      int start;
      int pick;
      start = $urandom_range(0, kcs_pkg::NCHARS - 1);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (distinct)
            send_item(kcs_pkg::OP_APPEND,
                      kcs_pkg::char_type'(kcs_pkg::FIRST_CHAR + (start + i) % kcs_pkg::NCHARS));
         else if (pick == 0)
            send_item(kcs_pkg::OP_APPEND, kcs_pkg::char_type'($urandom));
         else if (pick == 1)
            // A narrow range makes repeated key characters likely.
            send_item(kcs_pkg::OP_APPEND,
                      kcs_pkg::char_type'($urandom_range(kcs_pkg::FIRST_CHAR,
                                                         kcs_pkg::FIRST_CHAR + 5)));
         else
            send_item(kcs_pkg::OP_APPEND, any_printable());
      end
   endtask

   initial begin
      int choice;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.opcode    = kcs_pkg::OP_CLEAR;
      req_ch.data_char = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item(kcs_pkg::OP_ENCRYPT, "A");
      send_item(kcs_pkg::OP_DECRYPT, "z");
      send_item(kcs_pkg::OP_BUILD, 8'd0);
      send_item(kcs_pkg::OP_APPEND, 8'd0);
      send_item(kcs_pkg::OP_APPEND, 8'd31);
      send_item(kcs_pkg::OP_APPEND, 8'd127);
      send_item(kcs_pkg::OP_APPEND, 8'd255);
      send_item(kcs_pkg::OP_APPEND, "@");
      send_item(kcs_pkg::OP_APPEND, "~");
      send_item(kcs_pkg::OP_APPEND, " ");
      send_item(kcs_pkg::OP_APPEND, "@");
      send_item(kcs_pkg::OP_APPEND, "K");
      send_item(kcs_pkg::OP_BUILD, 8'd0);
      send_item(kcs_pkg::OP_ENCRYPT, " ");
      send_item(kcs_pkg::OP_ENCRYPT, "~");
      send_item(kcs_pkg::OP_ENCRYPT, 8'd200);
      send_item(kcs_pkg::OP_DECRYPT, 8'd0);
      send_item(kcs_pkg::OP_DECRYPT, "~");
      send_item(kcs_pkg::OP_ENCRYPT, "@");
      for (int op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++)
         send_item(kcs_pkg::op_type'(op), 8'd255);
      send_item(kcs_pkg::OP_CLEAR, 8'd255);
      // The old table stays in use after the keyword has been cleared.
      send_item(kcs_pkg::OP_ENCRYPT, "K");
      send_item(kcs_pkg::OP_BUILD, 8'd0);
      send_item(kcs_pkg::OP_DECRYPT, "K");

      while (items_sent < ITEM_TARGET) begin
         choice = $urandom_range(0, 11);
         if (choice == 0) begin
            repeat ($urandom_range(1, 4))
               send_item(kcs_pkg::op_type'($urandom_range(0, OP_SPARE_LAST)),
                         kcs_pkg::char_type'($urandom));
         end else if (choice == 1) begin
            send_item(kcs_pkg::OP_CLEAR, kcs_pkg::char_type'($urandom));
            send_item(kcs_pkg::OP_BUILD, kcs_pkg::char_type'($urandom));
            send_text($urandom_range(2, 8));
         end else begin
            if ($urandom_range(0, 5) != 0)
               send_item(kcs_pkg::OP_CLEAR, kcs_pkg::char_type'($urandom));
            if ($urandom_range(0, 9) == 0)
               load_keyword($urandom_range(KEY_CAP + 1, KEY_CAP + 8), 1'b1);
            else if ($urandom_range(0, 9) == 0)
               load_keyword($urandom_range(KEY_CAP - 4, KEY_CAP + 4), 1'b0);
            else
               load_keyword($urandom_range(1, 10), 1'b0);
            if ($urandom_range(0, 9) != 0)
               send_item(kcs_pkg::OP_BUILD, kcs_pkg::char_type'($urandom));
            send_text($urandom_range(5, 50));
         end
      end
      req_ch.valid <= 1'b0;

      while (predictor.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (predictor.fail_count == 0)
         $display("keyword_columnar_substitution_cipher test passed");
      else
         $display("keyword_columnar_substitution_cipher test failed");
      $finish;
   end

endmodule
